// File: rtl/rsf_pkg.sv
// Shared types, constants and the FNV-1a step for the row stream checker.
`default_nettype none

package rsf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned REASON_W = 3;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [WORD_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [POS_W-1:0]  PREFIX_LEN = 3'd4;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

    // Request codes on the input channel.
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_EOS  = 1'b1;

    typedef enum logic [REASON_W-1:0] {
        REASON_OK         = 3'd0,
        REASON_BAD_PREFIX = 3'd1,
        REASON_OPEN_LINE  = 3'd2,
        REASON_COUNT      = 3'd3,
        REASON_HASH       = 3'd4
    } t_fail_reason;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_ROWS = 1'b0,
        CFG_HASH_TARGET   = 1'b1
    } t_cfg_index;

    // Expected byte at each of the four prefix positions: "row ".
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [1:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            2'd0:    c = 8'h72;
            2'd1:    c = 8'h6F;
            2'd2:    c = 8'h77;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    // One FNV-1a step; the prime 2^24 + 403 is applied as shifts and adds.
    function automatic logic [WORD_W-1:0] fnv_step(
        input logic [WORD_W-1:0] hash,
        input logic [BYTE_W-1:0] b
    );
        logic [WORD_W-1:0] x;
        x = hash ^ {{(WORD_W-BYTE_W){1'b0}}, b};
        return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
    endfunction

endpackage

`default_nettype wire

// File: rtl/rsf_in_if.sv
// Input byte channel of the row stream checker.
`default_nettype none

interface rsf_in_if import rsf_pkg::*;;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, req_type, data_byte, input ready);
    modport sink   (input valid, req_type, data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/rsf_out_if.sv
// Result channel of the row stream checker.
`default_nettype none

interface rsf_out_if import rsf_pkg::*;;
    logic                valid;
    logic                ready;
    logic                stream_valid;
    logic [REASON_W-1:0] fail_reason;
    logic [WORD_W-1:0]   rows_counted;
    logic [WORD_W-1:0]   hash_value;

    modport source (output valid, stream_valid, fail_reason, rows_counted, hash_value,
                    input ready);
    modport sink   (input valid, stream_valid, fail_reason, rows_counted, hash_value,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/rsf_cfg_if.sv
// Register write channel of the row stream checker.
`default_nettype none

interface rsf_cfg_if import rsf_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/row_stream_fnv_checker.sv
// Row stream checker: FNV-1a hash, prefix check and row count over a byte stream.
//
// Usage:
//   i_in carries one beat per byte (req_type = data) or an end-of-stream beat
//   (req_type = end). Each data beat accepted before the prefix check fails
//   updates the running hash, the prefix check and the row count in the cycle
//   it is accepted. An end-of-stream beat produces one result beat on o_out
//   and clears the stream state. i_cfg writes expected_rows (index 0) or the
//   hash target (index 1); it is always ready. The user must see that it is
//   written only while no stream is in flight; the block does not enforce this.
// Throughput: one input beat per cycle while the skid register is not full.
//   The hash step (xor, then the constant multiply done as five shifted adds)
//   sits between the input port and the state registers.
// Stall: a two-entry output stage (result register plus skid register) holds
//   results while o_out.ready is low; i_in.ready drops only once the skid
//   register is full, and i_in.ready does not depend on o_out.ready.
// Reset: i_rst_n is synchronous, active low; it clears the stream state, sets
//   expected_rows to 0 and the hash target to the FNV offset basis, and empties
//   the output stage.
`default_nettype none

module row_stream_fnv_checker import rsf_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    rsf_in_if.sink    i_in,
    rsf_cfg_if.sink   i_cfg,
    rsf_out_if.source o_out
);

    typedef struct packed {
        logic                stream_valid;
        logic [REASON_W-1:0] fail_reason;
        logic [WORD_W-1:0]   rows_counted;
        logic [WORD_W-1:0]   hash_value;
    } t_result;

    logic [WORD_W-1:0] r_expected_rows;
    logic [WORD_W-1:0] r_hash_target;

    logic [WORD_W-1:0] r_hash, n_hash;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [WORD_W-1:0] r_rows, n_rows;
    logic              r_inside, n_inside;
    logic              r_failed, n_failed;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    t_result res;
    t_fail_reason reason;

    logic in_fire, eos_fire, out_free;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_valid;
    assign in_fire     = i_in.valid && i_in.ready;
    assign eos_fire    = in_fire && (i_in.req_type == REQ_EOS);
    assign out_free    = !r_out_valid || o_out.ready;

    // Result for an end-of-stream beat, checks in priority order.
    always_comb begin
        if (r_failed) begin
            reason = REASON_BAD_PREFIX;
        end else if (r_inside) begin
            reason = REASON_OPEN_LINE;
        end else if (r_rows != r_expected_rows) begin
            reason = REASON_COUNT;
        end else if (r_hash != r_hash_target) begin
            reason = REASON_HASH;
        end else begin
            reason = REASON_OK;
        end
        res.stream_valid = (reason == REASON_OK);
        res.fail_reason  = reason;
        res.rows_counted = r_rows;
        res.hash_value   = r_hash;
    end

    // Stream state update for one accepted beat.
    always_comb begin
        n_hash   = r_hash;
        n_pos    = r_pos;
        n_rows   = r_rows;
        n_inside = r_inside;
        n_failed = r_failed;
        if (in_fire) begin
            if (i_in.req_type == REQ_EOS) begin
                n_hash   = FNV_OFFSET;
                n_pos    = '0;
                n_rows   = '0;
                n_inside = 1'b0;
                n_failed = 1'b0;
            end else if (!r_failed) begin
                n_hash   = fnv_step(r_hash, i_in.data_byte);
                n_inside = 1'b1;
                if ((r_pos < PREFIX_LEN) && (i_in.data_byte != prefix_char(r_pos[1:0]))) begin
                    n_failed = 1'b1;
                end else begin
                    if (r_pos < PREFIX_LEN) begin
                        n_pos = r_pos + POS_W'(1);
                    end
                    if (i_in.data_byte == CHAR_LF) begin
                        if (r_rows != COUNT_MAX) begin
                            n_rows = r_rows + WORD_W'(1);
                        end
                        n_pos    = '0;
                        n_inside = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= FNV_OFFSET;
            r_pos    <= '0;
            r_rows   <= '0;
            r_inside <= 1'b0;
            r_failed <= 1'b0;
        end else begin
            r_hash   <= n_hash;
            r_pos    <= n_pos;
            r_rows   <= n_rows;
            r_inside <= n_inside;
            r_failed <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_rows <= '0;
            r_hash_target   <= FNV_OFFSET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_EXPECTED_ROWS: r_expected_rows <= i_cfg.data;
                CFG_HASH_TARGET:   r_hash_target   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Output stage: result register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || eos_fire;
            r_skid_valid <= 1'b0;
        end else if (eos_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (!out_free && eos_fire) begin
            r_skid <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.stream_valid = r_out.stream_valid;
    assign o_out.fail_reason  = r_out.fail_reason;
    assign o_out.rows_counted = r_out.rows_counted;
    assign o_out.hash_value   = r_out.hash_value;

endmodule

`default_nettype wire

// File: rtl/rsf_checker.sv
// Port-level assertions for the row stream checker, bound to the top level.
`default_nettype none

module rsf_checker import rsf_pkg::*; (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                i_in_ready,
    input wire                i_in_req_type,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire                i_out_stream_valid,
    input wire [REASON_W-1:0] i_out_fail_reason,
    input wire [WORD_W-1:0]   i_out_rows_counted,
    input wire [WORD_W-1:0]   i_out_hash_value
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_fail_reason)
            && $stable(i_out_rows_counted) && $stable(i_out_hash_value))
        else $error("result beat changed while stalled");

    // Pass flag agrees with the reason code.
    a_valid_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_stream_valid == (i_out_fail_reason == REASON_OK)))
        else $error("stream_valid disagrees with fail_reason");

    // A fresh result follows an accepted end-of-stream beat.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_req_type == REQ_EOS))
        else $error("result without end-of-stream beat");

    // Input backpressure only when results are backed up.
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty output");

endmodule

bind row_stream_fnv_checker rsf_checker u_rsf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_in_req_type      (i_in.req_type),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_stream_valid (o_out.stream_valid),
    .i_out_fail_reason  (o_out.fail_reason),
    .i_out_rows_counted (o_out.rows_counted),
    .i_out_hash_value   (o_out.hash_value)
);

`default_nettype wire

// File: tb/rsf_result_checker.sv
// Checker for the row stream checker: follows every channel, predicts each verdict and compares it.
`default_nettype none

module rsf_result_checker import rsf_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    rsf_in_if    i_in,
    rsf_cfg_if   i_cfg,
    rsf_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [WORD_W-1:0] FNV_MULT = 32'd16777619;
    localparam logic [WORD_W-1:0] ROW_TAG  = 32'h726F_7720;  // "row "
    localparam int                SHOW_MAX = 10;

    typedef struct packed {
        logic              stream_valid;
        t_fail_reason      reason;
        logic [WORD_W-1:0] rows;
        logic [WORD_W-1:0] hash;
    } t_verdict;

    t_verdict          verdict_q[$];
    logic [WORD_W-1:0] want_rows;
    logic [WORD_W-1:0] want_hash;
    logic [WORD_W-1:0] run_hash;
    logic [WORD_W-1:0] rows_seen;
    logic [POS_W-1:0]  prefix_idx;
    logic              in_line;
    logic              prefix_bad;
    int                fail_n;

    task automatic clear_stream();
        run_hash   = FNV_OFFSET;
        rows_seen  = '0;
        prefix_idx = '0;
        in_line    = 1'b0;
        prefix_bad = 1'b0;
    endtask

    // Fold one data byte into the stream state.
    task automatic take_byte(input logic [BYTE_W-1:0] b);
        int pos;
        pos = int'(prefix_idx);
        if (prefix_bad) return;
        in_line  = 1'b1;
        run_hash = (run_hash ^ {{(WORD_W-BYTE_W){1'b0}}, b}) * FNV_MULT;
        if (pos < 4) begin
            if (b != ROW_TAG[8*(3-pos) +: 8]) begin
                prefix_bad = 1'b1;
                return;
            end
            prefix_idx = prefix_idx + POS_W'(1);
        end
        if (b == CHAR_LF) begin
            if (rows_seen != COUNT_MAX) rows_seen = rows_seen + WORD_W'(1);
            prefix_idx = '0;
            in_line    = 1'b0;
        end
    endtask

    function automatic t_verdict close_stream();
        t_verdict v;
        if (prefix_bad)                 v.reason = REASON_BAD_PREFIX;
        else if (in_line)               v.reason = REASON_OPEN_LINE;
        else if (rows_seen != want_rows) v.reason = REASON_COUNT;
        else if (run_hash != want_hash) v.reason = REASON_HASH;
        else                            v.reason = REASON_OK;
        v.stream_valid = (v.reason == REASON_OK);
        v.rows         = rows_seen;
        v.hash         = run_hash;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            want_rows = '0;
            want_hash = FNV_OFFSET;
            clear_stream();
            verdict_q.delete();
            fail_n = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (t_cfg_index'(i_cfg.index) == CFG_EXPECTED_ROWS) want_rows = i_cfg.data;
                else                                              want_hash = i_cfg.data;
            end
            if (i_out.valid && i_out.ready) begin
                got.stream_valid = i_out.stream_valid;
                got.reason       = t_fail_reason'(i_out.fail_reason);
                got.rows         = i_out.rows_counted;
                got.hash         = i_out.hash_value;
                if (verdict_q.size() == 0) begin
                    if (fail_n < SHOW_MAX)
                        $display("[%0t] unexpected verdict: valid=%0b reason=%0d rows=%0d hash=%h",
                                 $realtime, got.stream_valid, got.reason, got.rows, got.hash);
                    fail_n++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) begin
                        if (fail_n < SHOW_MAX) begin
                            $display("[%0t] verdict mismatch", $realtime);
                            $display("    expected valid=%0b reason=%0d rows=%0d hash=%h",
                                     want.stream_valid, want.reason, want.rows, want.hash);
                            $display("    actual   valid=%0b reason=%0d rows=%0d hash=%h",
                                     got.stream_valid, got.reason, got.rows, got.hash);
                        end
                        fail_n++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.req_type == REQ_DATA) begin
                    take_byte(i_in.data_byte);
                end else begin
                    verdict_q.push_back(close_stream());
                    clear_stream();
                end
            end
        end
        o_fail_count <= fail_n;
        o_pending    <= verdict_q.size();
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Testbench top: clock, reset, byte stream and register stimulus, and the verdict.
`default_nettype none

module testbench import rsf_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL = 1900;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items;
    bit   calm;
    bit   send_noisy;
    bit   recv_noisy;
    int   stall_left;

    logic [BYTE_W-1:0] byte_plan[$];

    rsf_in_if  in_ch();
    rsf_cfg_if cfg_ch();
    rsf_out_if out_ch();

    row_stream_fnv_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    rsf_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #3ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Result side: random stall bursts while noisy, steady ready otherwise.
    initial begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        recv_noisy   = 1'b1;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) == 0) recv_noisy = !recv_noisy;
            if (stall_left > 0)
                stall_left--;
            else if (!calm && recv_noisy && $urandom_range(0, 2) == 0)
                stall_left = $urandom_range(1, 3);
            out_ch.ready = (stall_left == 0);
        end
    end

    // Send one beat; called and returning at a falling edge.
    task automatic push_beat(input logic req, input logic [BYTE_W-1:0] b);
        if ($urandom_range(0, 49) == 0) send_noisy = !send_noisy;
        if (!calm && send_noisy && $urandom_range(0, 3) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.req_type  = req;
        in_ch.data_byte = b;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic close_stream();
        push_beat(REQ_EOS, BYTE_W'($urandom));
        items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) push_beat(REQ_DATA, s[i]);
        items += s.len();
    endtask

    task automatic send_plan();
        foreach (byte_plan[i]) push_beat(REQ_DATA, byte_plan[i]);
        items += byte_plan.size();
    endtask

    function automatic logic [WORD_W-1:0] plan_hash();
        logic [WORD_W-1:0] h;
        h = FNV_OFFSET;
        foreach (byte_plan[i]) h = (h ^ {24'h0, byte_plan[i]}) * 32'd16777619;
        return h;
    endfunction

    // Hold the sender until every verdict is back and the block has gone quiet.
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [WORD_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Register writes, then a well-formed stream (maybe broken) once or twice, maybe noise.
    task automatic run_phase();
        int                n_rows;
        int                len;
        int                pick;
        int                at;
        logic [BYTE_W-1:0] c;
        logic [WORD_W-1:0] rows_cfg;
        logic [WORD_W-1:0] hash_cfg;
        string             tag;
        tag    = "row \n";
        n_rows = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
        byte_plan.delete();
        for (int r = 0; r < n_rows; r++) begin
            for (int i = 0; i < 4; i++) byte_plan.push_back(tag[i]);
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++) begin
                do c = BYTE_W'($urandom); while (c == CHAR_LF);
                byte_plan.push_back(c);
            end
            byte_plan.push_back(CHAR_LF);
        end
        rows_cfg = n_rows;
        hash_cfg = plan_hash();

        if ($urandom_range(0, 5) == 0) begin
            at = (byte_plan.size() > 0) ? $urandom_range(0, byte_plan.size() - 1) : 0;
            case ($urandom_range(0, 3))
                0: if (byte_plan.size() > 0) byte_plan[at] = BYTE_W'($urandom);
                1: if (byte_plan.size() > 0) void'(byte_plan.pop_back());
                2: byte_plan.insert(at, CHAR_LF);
                default: for (int i = 0; i < 3; i++) byte_plan.push_back(tag[i]);
            endcase
        end

        pick = $urandom_range(0, 9);
        case (pick)
            6: rows_cfg = rows_cfg + WORD_W'(1);
            7: hash_cfg = hash_cfg ^ (32'h1 << $urandom_range(0, 31));
            8: begin
                rows_cfg = COUNT_MAX;
                hash_cfg = '0;
            end
            9: begin
                rows_cfg = '0;
                hash_cfg = COUNT_MAX;
            end
            default: ;
        endcase

        drain();
        case ($urandom_range(0, 5))
            0: write_reg(CFG_EXPECTED_ROWS, rows_cfg);
            1: write_reg(CFG_HASH_TARGET, hash_cfg);
            default: begin
                write_reg(CFG_HASH_TARGET, hash_cfg);
                write_reg(CFG_EXPECTED_ROWS, rows_cfg);
            end
        endcase

        repeat ($urandom_range(1, 2)) begin
            send_plan();
            close_stream();
        end

        if ($urandom_range(0, 2) == 0) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                c = $urandom_range(0, 1) ? tag[i % 5] : BYTE_W'($urandom);
                push_beat(REQ_DATA, c);
            end
            items += len;
            close_stream();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.req_type  = REQ_DATA;
        in_ch.data_byte = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_EXPECTED_ROWS;
        cfg_ch.data     = '0;
        items           = 0;
        calm            = 1'b0;
        send_noisy      = 1'b1;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty stream against the reset registers passes.
        close_stream();
        // One good row while zero rows are expected.
        send_text("row \n");
        close_stream();
        // Bad first byte; the rest of the stream is ignored.
        push_beat(REQ_DATA, 8'hFF);
        push_beat(REQ_DATA, 8'h00);
        items += 2;
        close_stream();
        // Newline before the prefix is complete.
        send_text("ro\n");
        close_stream();
        // Last line never terminated.
        send_text("row 7");
        close_stream();

        // Right count, wrong hash; then both right.
        drain();
        write_reg(CFG_EXPECTED_ROWS, 32'd1);
        send_text("row \n");
        close_stream();
        byte_plan = '{8'h72, 8'h6F, 8'h77, 8'h20, CHAR_LF};
        drain();
        write_reg(CFG_HASH_TARGET, plan_hash());
        send_plan();
        close_stream();

        while (items < ITEM_GOAL) begin
            if (items > ITEM_GOAL * 4 / 5) calm = 1'b1;
            run_phase();
        end

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
